// File: hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types, constants and ring pointer helpers shared by the deque block.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int TAG_W  = 16;
    localparam int ENT_W  = VAL_W + TAG_W;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    typedef struct packed {
        t_op                      op;
        logic signed [VAL_W-1:0]  push_value;
        logic        [TAG_W-1:0]  push_tag;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]  popped_value;
        logic signed [VAL_W-1:0]  front_value;
        logic signed [VAL_W-1:0]  back_value;
        logic        [TAG_W-1:0]  front_tag;
        logic        [CNT_W-1:0]  occupancy;
        logic                     empty_flag;
        t_status                  status;
    } t_out_item;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        t_status           status;
        logic [CNT_W-1:0]  count_next;
        logic              was_empty;
    } t_ptr_cmd;

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ADDR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_prev(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == '0) begin
            r = ADDR_W'(DEPTH - 1);
        end else begin
            r = p - ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

// File: hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed values with index tags, kept in a
// ring buffer in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
// An item (op, push_value, push_tag) is taken at a rising edge where start
// is high and busy is low. Busy is high in the cycle after that, and in
// that same cycle o_strobe is high for one cycle with the result on o_out.
// A new item can be taken in the cycle after the result, so the block
// does not take a new item while the last one awaits its result. The
// result waits on the registered read of the entry RAM, which fetches
// the new front or back entry after a pop. Front and back entries are
// also held in registers, so pushes and the popped value need no read.
// Pushes to a full store and pops from an empty store change nothing and
// report a status code. Reset clears the pointers and the count; the RAM
// holds no defined data until written and needs no clearing. The receiver
// cannot stall: each result is valid only in its strobe cycle.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_out
);

    t_state                  r_state, n_state;
    t_ptr_cmd                cmd;
    logic                    accept;
    logic [ENT_W-1:0]        rd_data;
    logic signed [VAL_W-1:0] rd_value;
    logic        [TAG_W-1:0] rd_tag;

    logic signed [VAL_W-1:0] r_front_value;
    logic        [TAG_W-1:0] r_front_tag;
    logic signed [VAL_W-1:0] r_back_value;
    logic signed [VAL_W-1:0] r_popped;
    t_op                     r_op;
    t_status                 r_status;
    logic [CNT_W-1:0]        r_count;
    logic                    r_rd_en;

    logic signed [VAL_W-1:0] front_value;
    logic        [TAG_W-1:0] front_tag;
    logic signed [VAL_W-1:0] back_value;

    assign accept = start && !busy;

    deq_ptr u_ptr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_item.op),
        .o_cmd    (cmd)
    );

    deq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && cmd.wr_en),
        .i_waddr (cmd.wr_addr),
        .i_wdata ({i_item.push_tag, i_item.push_value}),
        .i_re    (accept && cmd.rd_en),
        .i_raddr (cmd.rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_value = signed'(rd_data[VAL_W-1:0]);
    assign rd_tag   = rd_data[ENT_W-1:VAL_W];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy     = 1'b0;
        o_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy     = 1'b0;
                o_strobe = 1'b0;
            end
            S_RESP: begin
                busy     = 1'b1;
                o_strobe = 1'b1;
            end
            default: begin
                busy     = 1'b0;
                o_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_en <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_rd_en <= cmd.rd_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_item.op;
            r_status <= cmd.status;
            r_count  <= cmd.count_next;
            r_popped <= '0;
            if (cmd.status == STAT_OK) begin
                case (i_item.op)
                    OP_PUSH_BACK: begin
                        r_back_value <= i_item.push_value;
                        if (cmd.was_empty) begin
                            r_front_value <= i_item.push_value;
                            r_front_tag   <= i_item.push_tag;
                        end
                    end
                    OP_PUSH_FRONT: begin
                        r_front_value <= i_item.push_value;
                        r_front_tag   <= i_item.push_tag;
                        if (cmd.was_empty) begin
                            r_back_value <= i_item.push_value;
                        end
                    end
                    OP_POP_FRONT: begin
                        r_popped <= r_front_value;
                    end
                    OP_POP_BACK: begin
                        r_popped <= r_back_value;
                    end
                    default: begin
                        r_popped <= '0;
                    end
                endcase
            end
        end else if (o_strobe && r_rd_en) begin
            r_front_value <= front_value;
            r_front_tag   <= front_tag;
            r_back_value  <= back_value;
        end
    end

    always_comb begin
        front_value = r_front_value;
        front_tag   = r_front_tag;
        back_value  = r_back_value;
        if (r_rd_en) begin
            if (r_op == OP_POP_FRONT) begin
                front_value = rd_value;
                front_tag   = rd_tag;
            end else begin
                back_value = rd_value;
            end
        end
    end

    always_comb begin
        o_out.popped_value = r_popped;
        o_out.occupancy    = r_count;
        o_out.empty_flag   = (r_count == '0);
        o_out.status       = r_status;
        if (r_count == '0) begin
            o_out.front_value = '0;
            o_out.front_tag   = '0;
            o_out.back_value  = '0;
        end else begin
            o_out.front_value = front_value;
            o_out.front_tag   = front_tag;
            o_out.back_value  = back_value;
        end
    end

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("Accepted item did not produce a result in the next cycle.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.status == STAT_FULL) |-> (o_out.occupancy == CNT_W'(DEPTH)))
        else $error("Full status reported while the store is not full.");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.status == STAT_EMPTY) |->
            (o_out.empty_flag && o_out.popped_value == '0))
        else $error("Pop from empty store reported a value or entries.");

    a_read_only_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd.rd_en) |-> !cmd.wr_en)
        else $error("Entry RAM read and written by the same item.");
`endif

endmodule

// File: hdl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/deq_ptr.sv
// ----------------------------------------------------------------------------
// deq_ptr
// Head, tail and count registers of the ring, with the memory access and
// status that each request causes.
// ----------------------------------------------------------------------------
module deq_ptr
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_op      i_op,
    output t_ptr_cmd o_cmd
);

    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] head_prev;
    logic [ADDR_W-1:0] head_next;
    logic [ADDR_W-1:0] tail_prev;

    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign head_prev = ring_prev(r_head);
    assign head_next = ring_next(r_head);
    assign tail_prev = ring_prev(r_tail);

    always_comb begin
        n_head           = r_head;
        n_tail           = r_tail;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_addr    = r_tail;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_addr    = head_next;
        o_cmd.status     = STAT_OK;
        o_cmd.count_next = r_count;
        o_cmd.was_empty  = empty;
        case (i_op)
            OP_PUSH_BACK: begin
                if (full) begin
                    o_cmd.status = STAT_FULL;
                end else begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_addr    = r_tail;
                    n_tail           = ring_next(r_tail);
                    o_cmd.count_next = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    o_cmd.status = STAT_FULL;
                end else begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_addr    = head_prev;
                    n_head           = head_prev;
                    o_cmd.count_next = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    o_cmd.status = STAT_EMPTY;
                end else begin
                    n_head           = head_next;
                    o_cmd.rd_addr    = head_next;
                    o_cmd.count_next = r_count - CNT_W'(1);
                    o_cmd.rd_en      = (r_count != CNT_W'(1));
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    o_cmd.status = STAT_EMPTY;
                end else begin
                    n_tail           = tail_prev;
                    o_cmd.rd_addr    = ring_prev(tail_prev);
                    o_cmd.count_next = r_count - CNT_W'(1);
                    o_cmd.rd_en      = (r_count != CNT_W'(1));
                end
            end
            default: begin
                o_cmd.status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= o_cmd.count_next;
        end
    end

endmodule
